// ===== hw/rtl/isbn13_string_validator_defines.svh =====
// assertion macros for the isbn-13 string validator
`ifndef ISBN13_STRING_VALIDATOR_DEFINES_SVH
`define ISBN13_STRING_VALIDATOR_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, quiet while rst is high
`define ISBN13_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also watched during reset
`define ISBN13_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ISBN13_ASSERT(label, prop, msg)
`define ISBN13_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== hw/rtl/isbn13_pkg.sv =====
// types, constants and helpers shared by the isbn-13 validator modules
package isbn13_pkg;

  typedef enum logic [2:0] {
    ST_VALID    = 3'd0,
    ST_BAD_CHAR = 3'd1,
    ST_TOO_MANY = 3'd2,
    ST_TOO_FEW  = 3'd3,
    ST_HYPHENS  = 3'd4,
    ST_PREFIX   = 3'd5,
    ST_CHECKSUM = 3'd6,
    ST_EXIT     = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_line;
  } item_t;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_EIGHT  = 8'h38;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_HYPHEN = 8'h2d;

  localparam logic [3:0] DIGITS_NEEDED  = 4'd13;
  localparam logic [3:0] DIGIT_SAT      = 4'd14;
  localparam logic [2:0] HYPHENS_NEEDED = 3'd4;
  localparam logic [2:0] HYPHEN_SAT     = 3'd5;
  localparam logic [1:0] POS_SAT        = 2'd3;
  localparam logic [3:0] TEN            = 4'd10;

  // 3*d mod 10 for a digit value
  function automatic logic [3:0] times3_mod10(input logic [3:0] d);
    logic [3:0] r;
    case (d)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd3;
      4'd2:    r = 4'd6;
      4'd3:    r = 4'd9;
      4'd4:    r = 4'd2;
      4'd5:    r = 4'd5;
      4'd6:    r = 4'd8;
      4'd7:    r = 4'd1;
      4'd8:    r = 4'd4;
      4'd9:    r = 4'd7;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/isbn13_string_validator.sv =====
// isbn-13 string validator: one character per transfer, one status per end of line
//
// input channel: in_valid / in_stall carry ch and end_of_line. a character
// transfer updates the running counts and mod-10 sum and gives no result. a
// transfer with end_of_line set closes the string and yields one status on
// the output channel (out_valid / out_stall / status), then clears the state.
// status: 0 valid, 1 bad char, 2 too many digits, 3 too few, 4 hyphens,
// 5 prefix, 6 checksum, 7 exit request (string is just "0").
// an end-of-line item passes the input register, then loads the result register.
// throughput: one transfer per cycle while in_stall is low; each character is
// folded into the state by one stage of counter and mod-10 logic behind the
// input register. a stalled status holds in the result register while
// characters keep flowing; only an end-of-line item waits, and with it the
// input register, so in_stall rises when out_stall holds a status and another
// end of line is pending.
// reset (rst, synchronous): both channels empty, string state cleared.
module isbn13_string_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] ch,
  input  logic       end_of_line,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status
);

  `include "isbn13_string_validator_defines.svh"

  isbn13_pkg::item_t   in_item;
  isbn13_pkg::item_t   held_item;
  isbn13_pkg::status_t verdict;
  logic                held_valid;
  logic                out_free;
  logic                advance;
  logic                result_load;

  assign in_item.ch          = ch;
  assign in_item.end_of_line = end_of_line;

  // a character always moves on; an end of line needs the result slot
  assign advance     = held_valid && (!held_item.end_of_line || out_free);
  assign result_load = advance && held_item.end_of_line;

  isbn13_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  isbn13_check u_check (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .item    (held_item),
    .verdict (verdict)
  );

  isbn13_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (result_load),
    .verdict   (verdict),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status)
  );

  `ISBN13_ASSERT(a_stall_only_on_eol,
    in_stall |-> (held_valid && held_item.end_of_line && out_valid && out_stall),
    "input stalled without a blocked end of line")
  `ISBN13_ASSERT(a_result_from_eol,
    $rose(out_valid) |-> $past(result_load),
    "status produced without an end-of-line transfer")
  `ISBN13_ASSERT(a_no_overwrite,
    (out_valid && out_stall) |-> !result_load,
    "waiting status overwritten")

endmodule

// ===== hw/rtl/isbn13_in_stage.sv =====
// input register that holds one accepted item until the check stage takes it
module isbn13_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  isbn13_pkg::item_t   in_item,
  input  logic                advance,
  output logic                held_valid,
  output isbn13_pkg::item_t   held_item
);

  logic take;

  assign in_stall = held_valid && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_item <= in_item;
    end
  end

endmodule

// ===== hw/rtl/isbn13_check.sv =====
// per-string state: counters, prefix match, weighted mod-10 sum and the verdict
module isbn13_check (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  isbn13_pkg::item_t   item,
  output isbn13_pkg::status_t verdict
);

  `include "isbn13_string_validator_defines.svh"

  logic [3:0] digit_count,   digit_count_next;
  logic [2:0] hyphen_count,  hyphen_count_next;
  logic       bad_char_seen, bad_char_seen_next;
  logic [1:0] char_position, char_position_next;
  logic       prefix_ok,     prefix_ok_next;
  logic       first_is_zero, first_is_zero_next;
  logic [3:0] sum_mod_ten,   sum_mod_ten_next;
  logic       weight_odd,    weight_odd_next;

  logic       is_digit;
  logic       is_hyphen;
  logic [3:0] term;
  logic [4:0] raw_sum;

  assign is_digit  = item.ch inside {[isbn13_pkg::CH_ZERO:isbn13_pkg::CH_NINE]};
  assign is_hyphen = (item.ch == isbn13_pkg::CH_HYPHEN);
  // low nibble of an ascii digit is its value
  assign term      = weight_odd ? isbn13_pkg::times3_mod10(item.ch[3:0]) : item.ch[3:0];
  assign raw_sum   = {1'b0, sum_mod_ten} + {1'b0, term};

  always_comb begin
    digit_count_next   = digit_count;
    hyphen_count_next  = hyphen_count;
    bad_char_seen_next = bad_char_seen;
    char_position_next = char_position;
    prefix_ok_next     = prefix_ok;
    first_is_zero_next = first_is_zero;
    sum_mod_ten_next   = sum_mod_ten;
    weight_odd_next    = weight_odd;
    if (item.end_of_line) begin
      digit_count_next   = '0;
      hyphen_count_next  = '0;
      bad_char_seen_next = 1'b0;
      char_position_next = '0;
      prefix_ok_next     = 1'b1;
      first_is_zero_next = 1'b0;
      sum_mod_ten_next   = '0;
      weight_odd_next    = 1'b0;
    end else begin
      case (char_position)
        2'd0: begin
          first_is_zero_next = (item.ch == isbn13_pkg::CH_ZERO);
          if (item.ch != isbn13_pkg::CH_NINE) prefix_ok_next = 1'b0;
        end
        2'd1: begin
          if (item.ch != isbn13_pkg::CH_SEVEN) prefix_ok_next = 1'b0;
        end
        2'd2: begin
          if (!(item.ch inside {isbn13_pkg::CH_EIGHT, isbn13_pkg::CH_NINE})) begin
            prefix_ok_next = 1'b0;
          end
        end
        default: ;
      endcase
      if (char_position < isbn13_pkg::POS_SAT) char_position_next = char_position + 2'd1;
      if (is_digit) begin
        sum_mod_ten_next = (raw_sum >= {1'b0, isbn13_pkg::TEN}) ?
                           4'(raw_sum - {1'b0, isbn13_pkg::TEN}) : raw_sum[3:0];
        weight_odd_next  = !weight_odd;
        if (digit_count < isbn13_pkg::DIGIT_SAT) digit_count_next = digit_count + 4'd1;
      end else if (is_hyphen) begin
        if (hyphen_count < isbn13_pkg::HYPHEN_SAT) hyphen_count_next = hyphen_count + 3'd1;
      end else begin
        bad_char_seen_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count   <= '0;
      hyphen_count  <= '0;
      bad_char_seen <= 1'b0;
      char_position <= '0;
      prefix_ok     <= 1'b1;
      first_is_zero <= 1'b0;
      sum_mod_ten   <= '0;
      weight_odd    <= 1'b0;
    end else if (fire) begin
      digit_count   <= digit_count_next;
      hyphen_count  <= hyphen_count_next;
      bad_char_seen <= bad_char_seen_next;
      char_position <= char_position_next;
      prefix_ok     <= prefix_ok_next;
      first_is_zero <= first_is_zero_next;
      sum_mod_ten   <= sum_mod_ten_next;
      weight_odd    <= weight_odd_next;
    end
  end

  // verdict on the string seen so far, first failing check wins
  always_comb begin
    if (char_position == 2'd1 && first_is_zero) begin
      verdict = isbn13_pkg::ST_EXIT;
    end else if (bad_char_seen) begin
      verdict = isbn13_pkg::ST_BAD_CHAR;
    end else if (digit_count > isbn13_pkg::DIGITS_NEEDED) begin
      verdict = isbn13_pkg::ST_TOO_MANY;
    end else if (digit_count < isbn13_pkg::DIGITS_NEEDED) begin
      verdict = isbn13_pkg::ST_TOO_FEW;
    end else if (hyphen_count != isbn13_pkg::HYPHENS_NEEDED) begin
      verdict = isbn13_pkg::ST_HYPHENS;
    end else if (!prefix_ok) begin
      verdict = isbn13_pkg::ST_PREFIX;
    end else if (sum_mod_ten != 4'd0) begin
      verdict = isbn13_pkg::ST_CHECKSUM;
    end else begin
      verdict = isbn13_pkg::ST_VALID;
    end
  end

  `ISBN13_ASSERT(a_clear_after_eol,
    $past(fire && item.end_of_line) |-> (digit_count == 4'd0 && hyphen_count == 3'd0 &&
      prefix_ok && !bad_char_seen && char_position == 2'd0),
    "state not cleared after end of line")
  `ISBN13_ASSERT(a_sum_range, sum_mod_ten < isbn13_pkg::TEN,
    "weighted sum left the mod-10 range")
  `ISBN13_ASSERT(a_count_sat,
    digit_count <= isbn13_pkg::DIGIT_SAT && hyphen_count <= isbn13_pkg::HYPHEN_SAT,
    "counter passed its saturation value")
  `ISBN13_ASSERT(a_weight_parity,
    (digit_count < isbn13_pkg::DIGIT_SAT) |-> (weight_odd == digit_count[0]),
    "weight parity disagrees with digit count")

endmodule

// ===== hw/rtl/isbn13_out_stage.sv =====
// result register holding one status until the receiver takes it
module isbn13_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  isbn13_pkg::status_t verdict,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          status
);

  // the slot is free when empty or being drained this cycle
  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= 3'(verdict);
    end
  end

endmodule
